// ===== rtl/btb_lru_pkg.sv =====
// Shared types and codes for the branch target buffer with LRU replacement.
package btb_lru_pkg;

  localparam int KindW  = 2;
  localparam int SlotW  = 4;
  localparam int PcW    = 32;
  localparam int PredW  = 2;
  localparam int CountW = 5;

  localparam int InDataW  = 72;
  localparam int OutDataW = 48;

  typedef enum logic [KindW-1:0] {
    KIND_LOOKUP  = 2'd0,
    KIND_INSERT  = 2'd1,
    KIND_RESOLVE = 2'd2,
    KIND_PREDICT = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PRED_UNKNOWN   = 2'd0,
    PRED_NOT_TAKEN = 2'd1,
    PRED_TAKEN     = 2'd2
  } pred_e;

  typedef enum logic [1:0] {
    TGT_ZERO = 2'd0,
    TGT_RAM  = 2'd1,
    TGT_NEW  = 2'd2
  } tgt_src_e;

  typedef struct packed {
    logic load;
    logic search;
    logic update;
    logic emit;
  } cmd_t;

endpackage

// ===== rtl/btb_lru_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module btb_lru_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/btb_lru_ctrl.sv =====
// Sequencer for the branch target buffer: accept, search, update, result.
module btb_lru_ctrl
  import btb_lru_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_tvalid_i,
  output logic s_tready_o,
  output logic m_tvalid_o,
  input  logic m_tready_i,
  output cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  logic [1:0] state_q, state_d;
  logic       m_tvalid_q, m_tvalid_d;
  logic       out_free;

  assign out_free   = !m_tvalid_q || m_tready_i;
  assign s_tready_o = (state_q == ST_IDLE);
  assign m_tvalid_o = m_tvalid_q;

  always_comb begin
    state_d     = state_q;
    m_tvalid_d  = m_tvalid_q && !m_tready_i;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd_o.search = 1'b1;
        state_d      = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          m_tvalid_d = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

endmodule

// ===== rtl/btb_lru_datapath.sv =====
// Slot storage, address match, victim search and result register of the buffer.
module btb_lru_datapath
  import btb_lru_pkg::*;
#(
  parameter int ENTRIES  = 16,
  parameter int AGE_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  input  kind_e             kind_i,
  input  logic [PcW-1:0]    branch_pc_i,
  input  logic [PcW-1:0]    target_pc_i,
  input  logic              taken_in_i,
  input  logic [SlotW-1:0]  slot_in_i,
  output logic              hit_o,
  output logic [SlotW-1:0]  slot_out_o,
  output logic [PcW-1:0]    target_out_o,
  output logic [PredW-1:0]  prediction_o,
  output logic [CountW-1:0] filled_count_o
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int NP = 1 << IW;
  localparam logic [AGE_BITS-1:0] AgeMax = {AGE_BITS{1'b1}};
  localparam logic [CW-1:0] CountMax = CW'(ENTRIES);

  // Item registers.
  kind_e             kind_q;
  logic [PcW-1:0]    pc_q;
  logic [PcW-1:0]    tgt_q;
  logic              taken_in_q;
  logic [SlotW-1:0]  sel_q;

  // Slot state.
  logic [PcW-1:0]      addr_q  [ENTRIES];
  logic                valid_q [ENTRIES];
  logic [PredW-1:0]    taken_q [ENTRIES];
  logic [AGE_BITS-1:0] age_q   [ENTRIES];
  logic [CW-1:0]       count_q;

  // Search results.
  logic          hit_q;
  logic [IW-1:0] match_idx_q;
  logic [IW-1:0] victim_q;

  // Update results.
  logic             res_hit_q;
  logic [SlotW-1:0] res_slot_q;
  logic [PredW-1:0] res_pred_q;
  tgt_src_e         src_q;

  // Output register.
  logic              out_hit_q;
  logic [SlotW-1:0]  out_slot_q;
  logic [PcW-1:0]    out_tgt_q;
  logic [PredW-1:0]  out_pred_q;
  logic [CountW-1:0] out_count_q;

  // Search trees.
  logic [AGE_BITS-1:0] vt_age [2*NP-1];
  logic [IW-1:0]       vt_idx [2*NP-1];
  logic                mt_hit [2*NP-1];
  logic [IW-1:0]       mt_idx [2*NP-1];

  for (genvar i = 0; i < NP; i++) begin : g_leaf
    if (i < ENTRIES) begin : g_real
      assign vt_age[NP-1+i] = age_q[i];
      assign mt_hit[NP-1+i] = valid_q[i] && (addr_q[i] == pc_q);
    end else begin : g_pad
      assign vt_age[NP-1+i] = '0;
      assign mt_hit[NP-1+i] = 1'b0;
    end
    assign vt_idx[NP-1+i] = IW'(i);
    assign mt_idx[NP-1+i] = IW'(i);
  end

  // Oldest wins with the lower index on a tie; the highest matching index wins.
  for (genvar n = 0; n < NP - 1; n++) begin : g_node
    assign vt_age[n] = (vt_age[2*n+2] > vt_age[2*n+1]) ? vt_age[2*n+2] : vt_age[2*n+1];
    assign vt_idx[n] = (vt_age[2*n+2] > vt_age[2*n+1]) ? vt_idx[2*n+2] : vt_idx[2*n+1];
    assign mt_hit[n] = mt_hit[2*n+1] | mt_hit[2*n+2];
    assign mt_idx[n] = mt_hit[2*n+2] ? mt_idx[2*n+2] : mt_idx[2*n+1];
  end

  // Update decisions.
  logic [PcW-1:0]   sel_w;
  logic             sel_ok;
  logic [IW-1:0]    upd_idx;
  logic             upd_hit;
  logic [SlotW-1:0] upd_slot;
  logic             use_pred;
  logic             do_touch;
  logic             do_fill;
  logic             do_resolve;
  logic [PredW-1:0] new_taken;
  logic [PredW-1:0] upd_pred;
  tgt_src_e         upd_src;

  assign sel_w     = PcW'(sel_q);
  assign sel_ok    = (sel_w < PcW'(ENTRIES));
  assign new_taken = taken_in_q ? PRED_TAKEN : PRED_NOT_TAKEN;

  always_comb begin
    upd_idx    = match_idx_q;
    upd_hit    = hit_q;
    upd_slot   = hit_q ? SlotW'(match_idx_q) : '0;
    use_pred   = hit_q;
    upd_src    = hit_q ? TGT_RAM : TGT_ZERO;
    do_touch   = 1'b0;
    do_fill    = 1'b0;
    do_resolve = 1'b0;
    unique case (kind_q)
      KIND_LOOKUP: begin
      end
      KIND_INSERT: begin
        do_touch = 1'b1;
        if (!hit_q) begin
          upd_idx  = victim_q;
          upd_slot = SlotW'(victim_q);
          use_pred = 1'b1;
          upd_src  = TGT_NEW;
          do_fill  = 1'b1;
        end
      end
      KIND_RESOLVE: begin
        do_resolve = hit_q;
      end
      KIND_PREDICT: begin
        upd_idx  = sel_w[IW-1:0];
        upd_slot = sel_q;
        upd_hit  = sel_ok && valid_q[sel_w[IW-1:0]];
        use_pred = sel_ok;
        upd_src  = sel_ok ? TGT_RAM : TGT_ZERO;
      end
      default: begin
      end
    endcase
    if (!use_pred) begin
      upd_pred = PRED_UNKNOWN;
    end else if (do_resolve) begin
      upd_pred = new_taken;
    end else begin
      upd_pred = taken_q[upd_idx];
    end
  end

  logic [PcW-1:0] ram_rdata;

  btb_lru_ram #(
    .WIDTH(PcW),
    .DEPTH(ENTRIES)
  ) u_target_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.update && do_fill),
    .waddr_i(upd_idx),
    .wdata_i(tgt_q),
    .raddr_i(upd_idx),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        valid_q[i] <= 1'b0;
        taken_q[i] <= PRED_UNKNOWN;
        age_q[i]   <= AGE_BITS'(1);
      end
      count_q <= '0;
    end else if (cmd_i.update) begin
      if (do_fill) begin
        valid_q[upd_idx] <= 1'b1;
        if (count_q != CountMax) begin
          count_q <= count_q + CW'(1);
        end
      end
      if (do_resolve) begin
        taken_q[upd_idx] <= new_taken;
      end
      if (do_touch) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (IW'(i) == upd_idx) begin
            age_q[i] <= '0;
          end else if (age_q[i] != AgeMax) begin
            age_q[i] <= age_q[i] + AGE_BITS'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q     <= kind_i;
      pc_q       <= branch_pc_i;
      tgt_q      <= target_pc_i;
      taken_in_q <= taken_in_i;
      sel_q      <= slot_in_i;
    end
    if (cmd_i.search) begin
      hit_q       <= mt_hit[0];
      match_idx_q <= mt_idx[0];
      victim_q    <= vt_idx[0];
    end
    if (cmd_i.update) begin
      if (do_fill) begin
        addr_q[upd_idx] <= pc_q;
      end
      res_hit_q  <= upd_hit;
      res_slot_q <= upd_slot;
      res_pred_q <= upd_pred;
      src_q      <= upd_src;
    end
    if (cmd_i.emit) begin
      out_hit_q   <= res_hit_q;
      out_slot_q  <= res_slot_q;
      out_pred_q  <= res_pred_q;
      out_count_q <= CountW'(count_q);
      unique case (src_q)
        TGT_RAM: out_tgt_q <= ram_rdata;
        TGT_NEW: out_tgt_q <= tgt_q;
        default: out_tgt_q <= '0;
      endcase
    end
  end

  assign hit_o          = out_hit_q;
  assign slot_out_o     = out_slot_q;
  assign target_out_o   = out_tgt_q;
  assign prediction_o   = out_pred_q;
  assign filled_count_o = out_count_q;

endmodule

// ===== rtl/branch_target_buffer_lru.sv =====
// Top level of the fully associative branch target buffer with LRU replacement.
//
// Channel  Dir  Handshake           Payload
// s        in   s_tvalid/s_tready   tuser: kind; tdata: branch_pc, target_pc, taken_in, slot_in
// m        out  m_tvalid/m_tready   tuser: hit; tdata: slot_out, target_out, prediction,
//                                   filled_count
//
// Each item passes through accept, parallel address match and oldest-slot search,
// state update with the target RAM read, and loading the result register.
// The next item is accepted once the previous one has reached the result register.
// Reset clears valid bits, taken states, fill count and sets every age to one.
// A stalled result holds the block in its last step until the result register frees.
module branch_target_buffer_lru
  import btb_lru_pkg::*;
#(
  parameter int ENTRIES  = 16,
  parameter int AGE_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  input  logic [KindW-1:0]    s_tuser_i,   // kind
  input  logic [InDataW-1:0]  s_tdata_i,   // branch_pc, target_pc, taken_in, slot_in, zero pad
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output logic                m_tuser_o,   // hit
  output logic [OutDataW-1:0] m_tdata_o    // slot_out, target_out, prediction, filled_count, pad
);

  cmd_t              cmd;
  logic [SlotW-1:0]  slot_out;
  logic [PcW-1:0]    target_out;
  logic [PredW-1:0]  prediction;
  logic [CountW-1:0] filled_count;

  btb_lru_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_tvalid_i),
    .s_tready_o(s_tready_o),
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready_i),
    .cmd_o     (cmd)
  );

  btb_lru_datapath #(
    .ENTRIES (ENTRIES),
    .AGE_BITS(AGE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .kind_i        (kind_e'(s_tuser_i)),
    .branch_pc_i   (s_tdata_i[31:0]),
    .target_pc_i   (s_tdata_i[63:32]),
    .taken_in_i    (s_tdata_i[64]),
    .slot_in_i     (s_tdata_i[68:65]),
    .hit_o         (m_tuser_o),
    .slot_out_o    (slot_out),
    .target_out_o  (target_out),
    .prediction_o  (prediction),
    .filled_count_o(filled_count)
  );

  assign m_tdata_o = {5'b0, filled_count, prediction, target_out, slot_out};

endmodule

// ===== tb/branch_target_buffer_lru_test.sv =====
// Self-checking testbench for the LRU branch target buffer with directed and random tests.
`timescale 1ns / 100ps

module branch_target_buffer_lru_test;
  import btb_lru_pkg::*;

  localparam int Entries       = 16;
  localparam int AgeBits       = 8;
  localparam int WatchdogLimit = 4000;
  localparam int PoolSize      = 24;

  typedef struct packed {
    logic              hit;
    logic [SlotW-1:0]  slot;
    logic [PcW-1:0]    target;
    pred_e             pred;
    logic [CountW-1:0] fill;
  } btb_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_tvalid_i = 1'b0;
  logic                s_tready_o;
  logic [KindW-1:0]    s_tuser_i = KIND_LOOKUP;
  logic [InDataW-1:0]  s_tdata_i = '0;
  logic                m_tvalid_o;
  logic                m_tready_i = 1'b0;
  logic                m_tuser_o;
  logic [OutDataW-1:0] m_tdata_o;

  logic [PcW-1:0]     btb_addr [Entries];
  logic [PcW-1:0]     btb_tgt [Entries];
  pred_e              btb_taken [Entries];
  logic [AgeBits-1:0] btb_age [Entries];
  logic               btb_valid [Entries];
  logic [CountW-1:0]  btb_fill;

  btb_result_t    pending_results[$];
  logic [PcW-1:0] pc_pool [PoolSize];
  int             send_idle_pct = 0;
  int             recv_stall_pct = 0;
  int             recv_hold = 0;
  int             error_count = 0;
  int             quiet_cycles = 0;

  branch_target_buffer_lru #(
    .ENTRIES (Entries),
    .AGE_BITS(AgeBits)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_tvalid_i),
    .s_tready_o(s_tready_o),
    .s_tuser_i (s_tuser_i),
    .s_tdata_i (s_tdata_i),
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready_i),
    .m_tuser_o (m_tuser_o),
    .m_tdata_o (m_tdata_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic btb_result_t read_slot(int idx, logic hit);
    btb_result_t r;
    r.hit    = hit;
    r.slot   = idx[SlotW-1:0];
    r.target = btb_tgt[idx];
    r.pred   = btb_taken[idx];
    r.fill   = btb_fill;
    return r;
  endfunction

  function automatic void touch_ages(int used);
    for (int i = 0; i < Entries; i++) begin
      if (btb_age[i] != '1) btb_age[i] = btb_age[i] + 1'b1;
    end
    btb_age[used] = '0;
  endfunction

  function automatic btb_result_t btb_access(kind_e kind, logic [PcW-1:0] pc,
                                             logic [PcW-1:0] tgt, logic taken,
                                             logic [SlotW-1:0] sel);
    btb_result_t        r;
    int                 match;
    int                 victim;
    logic [AgeBits-1:0] oldest;
    r.hit    = 1'b0;
    r.slot   = '0;
    r.target = '0;
    r.pred   = PRED_UNKNOWN;
    r.fill   = btb_fill;
    match    = -1;
    for (int i = 0; i < Entries; i++) begin
      if (btb_valid[i] && btb_addr[i] == pc) match = i;
    end
    case (kind)
      KIND_LOOKUP: begin
        if (match >= 0) r = read_slot(match, 1'b1);
      end
      KIND_INSERT: begin
        if (match >= 0) begin
          touch_ages(match);
          r = read_slot(match, 1'b1);
        end else begin
          oldest = '0;
          victim = 0;
          for (int i = 0; i < Entries; i++) begin
            if (btb_age[i] > oldest) begin
              oldest = btb_age[i];
              victim = i;
            end
          end
          btb_addr[victim]  = pc;
          btb_tgt[victim]   = tgt;
          btb_valid[victim] = 1'b1;
          if (btb_fill < Entries) btb_fill = btb_fill + 1'b1;
          touch_ages(victim);
          r = read_slot(victim, 1'b0);
        end
      end
      KIND_RESOLVE: begin
        for (int i = 0; i < Entries; i++) begin
          if (btb_valid[i] && btb_addr[i] == pc) begin
            if (taken) begin
              btb_taken[i] = PRED_TAKEN;
            end else begin
              btb_taken[i] = PRED_NOT_TAKEN;
            end
          end
        end
        if (match >= 0) r = read_slot(match, 1'b1);
      end
      default: begin
        r = read_slot(int'(sel), btb_valid[sel]);
      end
    endcase
    return r;
  endfunction

  task automatic send_item(kind_e kind, logic [PcW-1:0] pc, logic [PcW-1:0] tgt,
                           logic taken, logic [SlotW-1:0] sel);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= kind;
    s_tdata_i  <= {3'b000, sel, taken, tgt, pc};
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    pending_results.push_back(btb_access(kind, pc, tgt, taken, sel));
    @(negedge clk_i);
  endtask

  function automatic logic [SlotW-1:0] pick_filled_slot();
    logic [SlotW-1:0] sel;
    do sel = SlotW'($urandom_range(Entries - 1)); while (!btb_valid[sel]);
    return sel;
  endfunction

  function automatic logic [PcW-1:0] pick_pc();
    if ($urandom_range(99) < 80) return pc_pool[$urandom_range(PoolSize - 1)];
    return $urandom;
  endfunction

  task automatic check_field(string name, logic [PcW-1:0] want, logic [PcW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(negedge clk_i) begin
    if (recv_hold > 0) begin
      m_tready_i <= 1'b0;
      recv_hold--;
    end else begin
      m_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    btb_result_t want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual hit %b data %h",
                 $time, m_tuser_o, m_tdata_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("hit", PcW'(want.hit), PcW'(m_tuser_o));
        check_field("slot_out", PcW'(want.slot), PcW'(m_tdata_o[3:0]));
        check_field("target_out", want.target, m_tdata_o[35:4]);
        check_field("prediction", PcW'(want.pred), PcW'(m_tdata_o[37:36]));
        check_field("filled_count", PcW'(want.fill), PcW'(m_tdata_o[42:38]));
      end
    end
    if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: no item moved for %0d cycles", $time, WatchdogLimit);
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic test_directed();
    logic [PcW-1:0] pc;
    pc = $urandom;
    send_item(KIND_LOOKUP, '0, '0, 1'b0, '0);
    send_item(KIND_LOOKUP, '1, '1, 1'b1, '1);
    send_item(KIND_RESOLVE, '0, '0, 1'b1, '0);
    send_item(KIND_INSERT, '0, '1, 1'b0, '0);
    send_item(KIND_INSERT, '1, '0, 1'b1, '1);
    send_item(KIND_INSERT, '0, 32'h1234_5678, 1'b0, '0);
    send_item(KIND_LOOKUP, '0, '0, 1'b0, '0);
    send_item(KIND_RESOLVE, '0, '0, 1'b1, '0);
    send_item(KIND_RESOLVE, '1, '1, 1'b0, '1);
    send_item(KIND_PREDICT, '0, '0, 1'b0, 4'd0);
    send_item(KIND_PREDICT, '1, '1, 1'b1, 4'd1);
    send_item(KIND_LOOKUP, '1, '0, 1'b0, '0);
    send_item(KIND_INSERT, pc, ~pc, 1'b0, '0);
    send_item(KIND_RESOLVE, pc, '0, 1'b1, '0);
    send_item(KIND_LOOKUP, ~pc, '0, 1'b0, '0);
    send_item(KIND_PREDICT, '0, '0, 1'b0, 4'd2);
  endtask

  task automatic test_random_traffic(int count);
    int roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 35) begin
        send_item(KIND_INSERT, pick_pc(), $urandom, 1'($urandom), SlotW'($urandom));
      end else if (roll < 60 || btb_fill == 0) begin
        send_item(KIND_LOOKUP, pick_pc(), $urandom, 1'($urandom), SlotW'($urandom));
      end else if (roll < 80) begin
        send_item(KIND_RESOLVE, pick_pc(), $urandom, 1'($urandom), SlotW'($urandom));
      end else begin
        send_item(KIND_PREDICT, $urandom, $urandom, 1'($urandom), pick_filled_slot());
      end
    end
  endtask

  // Two branches hit over and over, so every other slot's age saturates and the
  // following misses must pick the lowest index among the tied oldest slots.
  task automatic test_hot_loop(int count);
    logic [PcW-1:0] hot [2];
    int             roll;
    hot[0] = $urandom;
    hot[1] = ~hot[0];
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 95) begin
        send_item(KIND_INSERT, hot[$urandom_range(1)], $urandom, 1'($urandom),
                  SlotW'($urandom));
      end else if (roll < 98) begin
        send_item(KIND_LOOKUP, hot[$urandom_range(1)], $urandom, 1'($urandom),
                  SlotW'($urandom));
      end else begin
        send_item(KIND_PREDICT, $urandom, $urandom, 1'($urandom), pick_filled_slot());
      end
    end
    for (int n = 0; n < 6; n++) begin
      send_item(KIND_INSERT, $urandom, $urandom, 1'($urandom), SlotW'($urandom));
    end
  endtask

  task automatic test_backpressure(int count);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    recv_hold      = 200;
    test_random_traffic(count);
  endtask

  initial begin
    for (int i = 0; i < Entries; i++) begin
      btb_addr[i]  = '0;
      btb_tgt[i]   = '0;
      btb_taken[i] = PRED_UNKNOWN;
      btb_age[i]   = AgeBits'(1);
      btb_valid[i] = 1'b0;
    end
    btb_fill   = '0;
    pc_pool[0] = '0;
    pc_pool[1] = '1;
    for (int i = 2; i < PoolSize; i++) pc_pool[i] = $urandom;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    test_directed();
    test_random_traffic(150);
    send_idle_pct = 57;
    test_random_traffic(150);
    send_idle_pct  = 0;
    recv_stall_pct = 57;
    test_random_traffic(150);
    send_idle_pct  = 14;
    recv_stall_pct = 14;
    test_random_traffic(150);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_hot_loop(290);
    test_backpressure(40);
    s_tvalid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
